FILE: rtl/gerb_pkg.sv
// ----------------------------------------------------------------------------
// gerb_pkg
// Shared types, constants and helpers of the graphics engine register block.
// ----------------------------------------------------------------------------
`default_nettype none

package gerb_pkg;

    localparam int unsigned WINDOW_BYTES       = 8192;
    localparam int unsigned WORDS              = WINDOW_BYTES / 4;
    localparam int unsigned ADDR_W             = $clog2(WORDS);

    localparam logic [15:0] INTR_OFFSET        = 16'd256;
    localparam logic [15:0] STATUS_OFFSET      = 16'd1792;
    localparam logic [15:0] FIFO_OFFSET        = 16'd1824;
    localparam logic [15:0] CTX_CONTROL_OFFSET = 16'd324;
    localparam logic [31:0] CS_INTR_MASK       = 32'h0000_1000;

    localparam logic [1:0]  FUNC_READ          = 2'd0;
    localparam logic [1:0]  FUNC_WRITE         = 2'd1;
    localparam logic [1:0]  FUNC_EVENT         = 2'd2;

    localparam logic [1:0]  STATUS_OK          = 2'd0;
    localparam logic [1:0]  STATUS_RANGE       = 2'd1;
    localparam logic [1:0]  STATUS_SIZE        = 2'd2;

    localparam logic [2:0]  SIZE_BYTE          = 3'd1;
    localparam logic [2:0]  SIZE_HALF          = 3'd2;
    localparam logic [2:0]  SIZE_WORD          = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] byte_offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic        engine_busy;
    } gerb_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  access_status;
        logic        fifo_kick;
        logic        irq_recompute;
        logic [31:0] interrupt_pending;
        logic [31:0] work_count;
    } gerb_out_t;

    typedef struct packed {
        logic              load;
        logic              mem_rd;
        logic              exec;
        logic              clear_we;
        logic [ADDR_W-1:0] clear_addr;
    } gerb_cmd_t;

    function automatic logic [31:0] lane_mask(input logic [2:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gerb_ctrl.sv
// ----------------------------------------------------------------------------
// gerb_ctrl
// Sequencer: clearing pass after reset, then accept / lookup / execute per
// transfer, with the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module gerb_ctrl
    import gerb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output gerb_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic              in_ready_reg, in_ready_next;
    logic              out_valid_reg, out_valid_next;
    logic              exec_go;

    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
                if (clear_cnt_reg == ADDR_W'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready       = in_ready_reg;
    assign out_valid      = out_valid_reg;
    assign cmd.load       = in_valid && in_ready_reg;
    assign cmd.mem_rd     = (state_reg == S_LOOKUP);
    assign cmd.exec       = exec_go;
    assign cmd.clear_we   = (state_reg == S_CLEAR);
    assign cmd.clear_addr = clear_cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/gerb_dp.sv
// ----------------------------------------------------------------------------
// gerb_dp
// Datapath: item register, scratch word memory, interrupt and work counter
// registers, access decode and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gerb_dp
    import gerb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire gerb_cmd_t cmd,
    input  wire gerb_in_t  in_data,
    output gerb_out_t      out_data
);

    gerb_in_t          item_reg;
    gerb_out_t         out_reg;
    logic [31:0]       scratch_mem [WORDS];
    logic [31:0]       rdata_reg;
    logic [31:0]       pending_reg, pending_next;
    logic [31:0]       work_reg, work_next;

    logic [ADDR_W-1:0] word_idx;
    logic [4:0]        shift;
    logic [31:0]       lmask, wmask, wbits, rword, rlane, merged;
    logic              is_word, good_size, beyond, item_we;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    gerb_out_t         result;

    assign word_idx = item_reg.byte_offset[ADDR_W+1:2];

    always_comb
    begin
        shift     = {item_reg.byte_offset[1:0], 3'b000};
        lmask     = lane_mask(item_reg.access_size);
        is_word   = (item_reg.access_size == SIZE_WORD);
        good_size = (item_reg.access_size == SIZE_BYTE)
                 || (item_reg.access_size == SIZE_HALF) || is_word;
        beyond    = (({1'b0, item_reg.byte_offset} + 17'(item_reg.access_size))
                     > 17'(WINDOW_BYTES))
                 || ({1'b0, item_reg.byte_offset[15:2]} >= 15'(WORDS));
        wmask     = is_word ? 32'hFFFF_FFFF : (lmask << shift);
        wbits     = is_word ? item_reg.write_data
                            : ((item_reg.write_data & lmask) << shift);
        merged    = (rdata_reg & ~wmask) | wbits;
        rword     = (item_reg.byte_offset == INTR_OFFSET) ? pending_reg : rdata_reg;
        if (item_reg.byte_offset == STATUS_OFFSET)
        begin
            rword[0] = item_reg.engine_busy;
        end
        rlane     = is_word ? rword : ((rword >> shift) & lmask);

        result                   = '0;
        pending_next             = pending_reg;
        work_next                = work_reg;
        item_we                  = 1'b0;
        case (item_reg.func)
            FUNC_EVENT:
            begin
                pending_next         = pending_reg | CS_INTR_MASK;
                result.irq_recompute = 1'b1;
            end
            FUNC_READ, FUNC_WRITE:
            begin
                if (beyond)
                begin
                    result.access_status = STATUS_RANGE;
                end
                else if (!good_size)
                begin
                    result.access_status = STATUS_SIZE;
                end
                else if (item_reg.func == FUNC_READ)
                begin
                    result.read_data = rlane;
                end
                else if (item_reg.byte_offset == INTR_OFFSET)
                begin
                    pending_next         = pending_reg & ~wbits;
                    result.irq_recompute = 1'b1;
                end
                else
                begin
                    item_we          = 1'b1;
                    result.fifo_kick = (item_reg.byte_offset == FIFO_OFFSET) && is_word
                                    && item_reg.write_data[0];
                    if ((item_reg.byte_offset == CTX_CONTROL_OFFSET) && is_word)
                    begin
                        work_next = work_reg + 32'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.access_status     = result.access_status;
        result.interrupt_pending = pending_next;
        result.work_count        = work_next;
    end

    assign mem_we    = cmd.clear_we || (cmd.exec && item_we);
    assign mem_addr  = cmd.clear_we ? cmd.clear_addr : word_idx;
    assign mem_wdata = cmd.clear_we ? 32'd0 : merged;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            scratch_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= scratch_mem[word_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.exec)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            work_reg    <= '0;
        end
        else if (cmd.exec)
        begin
            pending_reg <= pending_next;
            work_reg    <= work_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

FILE: rtl/graphics_engine_register_block_core.sv
// ----------------------------------------------------------------------------
// graphics_engine_register_block_core
// Register window of a graphics engine: bus reads, byte/half/word writes and
// context-switch events against a scratch word file and control registers.
//
// Input channel (in_valid/in_ready/in_data) takes one access or event per
// transfer; output channel (out_valid/out_ready/out_data) returns exactly one
// result per input transfer, in order.
// After reset the scratch file is cleared one word per cycle; in_ready stays
// low until all WORDS words (2048 at the default window) have been cleared.
// Each item goes through accept, scratch memory read (registered read
// port), then decode, read-modify-write and result capture. A new item is
// accepted only after the previous one has been executed.
// The result sits in an output register; the next item is accepted and looked
// up while it waits, and its execute step holds until out_ready frees the
// register. No state changes while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module graphics_engine_register_block_core
    import gerb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire gerb_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output gerb_out_t      out_data
);

    gerb_cmd_t cmd;

    gerb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    gerb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/gerb_checker.sv
// ----------------------------------------------------------------------------
// gerb_checker
// Port-level checks of the register block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gerb_checker
    import gerb_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire gerb_out_t out_data
);

    // result held until transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer accepted back to back");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.access_status == STATUS_OK)
            || (out_data.access_status == STATUS_RANGE)
            || (out_data.access_status == STATUS_SIZE))
        else $error("undefined access status");

    // errors give no data and no pulses
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.access_status != STATUS_OK)
        |-> (out_data.read_data == 32'd0) && !out_data.fifo_kick
            && !out_data.irq_recompute)
        else $error("side effect on failed access");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fifo_kick |-> !out_data.irq_recompute)
        else $error("kick and interrupt update on one item");

endmodule

bind graphics_engine_register_block_core gerb_checker u_gerb_checker (.*);

`default_nettype wire
